### hdl/tga_rle_pkg.sv
// shared types and codes for the tga run-length pixel decoder
`timescale 1ns / 1ps

package tga_rle_pkg;

   // request kinds on the input channel
   localparam logic REQ_DATA = 1'b0;
   localparam logic REQ_END  = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_PIXEL      = 2'd0,
      STATUS_BAD_HEADER = 2'd1,
      STATUS_TRUNCATED  = 2'd2
   } status_type;

   // parse phase of the byte stream
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_PACKET = 2'd1,
      PH_PIXEL  = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   // sub-header layout
   localparam int          HEADER_LAST   = 5;
   localparam logic [23:0] DEPTH_RGB     = 24'd24;
   localparam logic [23:0] DEPTH_RGBA    = 24'd32;
   localparam logic [7:0]  RUN_THRESHOLD = 8'd128;
   localparam logic [7:0]  RUN_BIAS      = 8'd127;

   typedef struct packed {
      status_type  status;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        has_alpha;
      logic [7:0]  repeat_count;
      logic        last_of_image;
   } result_type;

endpackage

### hdl/tga_rle_pixel_decoder.sv
// top level of the tga run-length pixel decoder
`timescale 1ns / 1ps

// Decodes a run-length-coded TGA byte stream, one byte per transaction, starting at the
// six-byte image sub-header (width and height little endian, depth, one ignored byte).
// Only 24- and 32-bit images are accepted; a zero dimension or another depth gives one
// bad-header result. Raw packets give one result per pixel, run packets one result with a
// repeat count, clipped to the pixels left in the image. Pixels leave as R,G,B(,A); alpha
// is zero for 24-bit images. An end-of-stream transaction before the image is complete
// gives a truncation result; after completion or an error it gives none. Either way the
// decoder then waits for a new sub-header. Rate: one byte per clock cycle while req_stall
// is low; each byte passes the combinational parse logic, and its result, if any, is
// registered in the output register, or in the skid register while the output stalls.
// The only multiply (width times height) is done once per image into the pixel counter.
// Output and skid register form a two-entry stage; req_stall rises only when both are full.
module tga_rle_pixel_decoder (
   input  logic                    clock,
   input  logic                    reset,
   // byte transactions in
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_type,
   input  logic [7:0]              req_data_byte,
   // result transactions out
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output tga_rle_pkg::status_type rsp_status,
   output logic [7:0]              rsp_red,
   output logic [7:0]              rsp_green,
   output logic [7:0]              rsp_blue,
   output logic [7:0]              rsp_alpha,
   output logic                    rsp_has_alpha,
   output logic [7:0]              rsp_repeat_count,
   output logic                    rsp_last_of_image
);
   import tga_rle_pkg::*;

   // parse state
   phase_type   phase_ff,         phase_in;
   logic [2:0]  header_index_ff,  header_index_in;
   logic [15:0] image_width_ff,   image_width_in;
   logic [15:0] image_height_ff,  image_height_in;
   logic        four_channels_ff, four_channels_in;
   logic [31:0] pixels_left_ff,   pixels_left_in;
   logic [7:0]  packet_left_ff,   packet_left_in;
   logic        packet_is_run_ff, packet_is_run_in;
   logic [1:0]  byte_in_pixel_ff, byte_in_pixel_in;
   logic [23:0] pixel_bytes_ff,   pixel_bytes_in;

   // output stage
   logic        rsp_valid_ff,  rsp_valid_in;
   result_type  rsp_data_ff,   rsp_data_in;
   logic        skid_valid_ff, skid_valid_in;
   result_type  skid_data_ff,  skid_data_in;

   logic        req_accept;
   logic        new_valid;
   result_type  new_result;
   logic        out_free;

   // emit helpers
   logic [31:0] image_area;
   logic [23:0] pixel_word;
   logic [31:0] run_clip;
   logic [7:0]  emit_repeat;
   logic [31:0] pixels_after;
   logic [7:0]  packet_after;
   logic        emit_last;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // once per image, product goes straight into the pixel counter
   assign image_area = 32'(image_width_ff) * 32'(image_height_ff);

   // pixel word including the byte arriving now (blue low, red high)
   always_comb begin
      pixel_word = pixel_bytes_ff;
      unique case (byte_in_pixel_ff)
         2'd0:    pixel_word[7:0]   = req_data_byte;
         2'd1:    pixel_word[15:8]  = req_data_byte;
         2'd2:    pixel_word[23:16] = req_data_byte;
         default: pixel_word        = pixel_bytes_ff;
      endcase
   end

   // repeat count, clipped to what is left of the image
   always_comb begin
      run_clip = (32'(packet_left_ff) > pixels_left_ff) ? pixels_left_ff
                                                        : 32'(packet_left_ff);
      emit_repeat  = packet_is_run_ff ? run_clip[7:0] : 8'd1;
      pixels_after = pixels_left_ff - 32'(emit_repeat);
      packet_after = packet_is_run_ff ? 8'd0 : packet_left_ff - 8'd1;
      emit_last    = (pixels_after == 32'd0);
   end

   // parse step for one byte transaction
   always_comb begin
      phase_in         = phase_ff;
      header_index_in  = header_index_ff;
      image_width_in   = image_width_ff;
      image_height_in  = image_height_ff;
      four_channels_in = four_channels_ff;
      pixels_left_in   = pixels_left_ff;
      packet_left_in   = packet_left_ff;
      packet_is_run_in = packet_is_run_ff;
      byte_in_pixel_in = byte_in_pixel_ff;
      pixel_bytes_in   = pixel_bytes_ff;
      new_valid        = 1'b0;
      new_result       = '0;
      new_result.status        = STATUS_PIXEL;
      new_result.last_of_image = 1'b1;

      if (req_accept) begin
         if (req_type == REQ_END) begin
            // truncation unless the image was finished or rejected
            if (phase_ff != PH_DONE) begin
               new_valid         = 1'b1;
               new_result.status = STATUS_TRUNCATED;
            end
            phase_in         = PH_HEADER;
            header_index_in  = '0;
            byte_in_pixel_in = '0;
            pixel_bytes_in   = '0;
            packet_left_in   = '0;
            packet_is_run_in = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  unique case (header_index_ff)
                     3'd0:    image_width_in  = {8'd0, req_data_byte};
                     3'd1:    image_width_in  = {req_data_byte, image_width_ff[7:0]};
                     3'd2:    image_height_in = {8'd0, req_data_byte};
                     3'd3:    image_height_in = {req_data_byte, image_height_ff[7:0]};
                     3'd4:    pixel_bytes_in  = {16'd0, req_data_byte};
                     default: pixel_bytes_in  = pixel_bytes_ff;
                  endcase
                  if (header_index_ff != 3'(HEADER_LAST)) begin
                     header_index_in = header_index_ff + 3'd1;
                  end else begin
                     header_index_in = '0;
                     pixel_bytes_in  = '0;
                     if (image_width_ff == 16'd0 || image_height_ff == 16'd0 ||
                         (pixel_bytes_ff != DEPTH_RGB && pixel_bytes_ff != DEPTH_RGBA)) begin
                        phase_in          = PH_DONE;
                        new_valid         = 1'b1;
                        new_result.status = STATUS_BAD_HEADER;
                     end else begin
                        four_channels_in = (pixel_bytes_ff == DEPTH_RGBA);
                        pixels_left_in   = image_area;
                        phase_in         = PH_PACKET;
                     end
                  end
               end
               PH_PACKET: begin
                  // below the threshold: raw packet, else a run
                  if (req_data_byte < RUN_THRESHOLD) begin
                     packet_is_run_in = 1'b0;
                     packet_left_in   = req_data_byte + 8'd1;
                  end else begin
                     packet_is_run_in = 1'b1;
                     packet_left_in   = req_data_byte - RUN_BIAS;
                  end
                  byte_in_pixel_in = '0;
                  pixel_bytes_in   = '0;
                  phase_in         = PH_PIXEL;
               end
               PH_PIXEL: begin
                  pixel_bytes_in   = pixel_word;
                  byte_in_pixel_in = byte_in_pixel_ff + 2'd1;
                  // pixel complete on third byte (rgb) or fourth byte (rgba)
                  if ((byte_in_pixel_ff == 2'd2 && !four_channels_ff) ||
                      byte_in_pixel_ff == 2'd3) begin
                     new_valid                = 1'b1;
                     new_result.status        = STATUS_PIXEL;
                     new_result.red           = pixel_word[23:16];
                     new_result.green         = pixel_word[15:8];
                     new_result.blue          = pixel_word[7:0];
                     new_result.alpha         = (byte_in_pixel_ff == 2'd3) ? req_data_byte
                                                                           : 8'd0;
                     new_result.has_alpha     = four_channels_ff;
                     new_result.repeat_count  = emit_repeat;
                     new_result.last_of_image = emit_last;
                     packet_left_in           = packet_after;
                     pixels_left_in           = pixels_after;
                     byte_in_pixel_in         = '0;
                     pixel_bytes_in           = '0;
                     priority if (emit_last) begin
                        phase_in = PH_DONE;
                     end else if (packet_after == 8'd0) begin
                        phase_in = PH_PACKET;
                     end else begin
                        phase_in = PH_PIXEL;
                     end
                  end
               end
               PH_DONE: begin
                  // bytes after completion or a bad header are dropped
                  phase_in = PH_DONE;
               end
            endcase
         end
      end
   end

   // output register plus skid register, results stay in order
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (new_valid) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = new_result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = new_result;
         end
      end else begin
         if (out_free) begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         header_index_ff  <= '0;
         image_width_ff   <= '0;
         image_height_ff  <= '0;
         four_channels_ff <= 1'b0;
         pixels_left_ff   <= '0;
         packet_left_ff   <= '0;
         packet_is_run_ff <= 1'b0;
         byte_in_pixel_ff <= '0;
         pixel_bytes_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         header_index_ff  <= header_index_in;
         image_width_ff   <= image_width_in;
         image_height_ff  <= image_height_in;
         four_channels_ff <= four_channels_in;
         pixels_left_ff   <= pixels_left_in;
         packet_left_ff   <= packet_left_in;
         packet_is_run_ff <= packet_is_run_in;
         byte_in_pixel_ff <= byte_in_pixel_in;
         pixel_bytes_ff   <= pixel_bytes_in;
         rsp_valid_ff     <= rsp_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_data_ff.status;
   assign rsp_red           = rsp_data_ff.red;
   assign rsp_green         = rsp_data_ff.green;
   assign rsp_blue          = rsp_data_ff.blue;
   assign rsp_alpha         = rsp_data_ff.alpha;
   assign rsp_has_alpha     = rsp_data_ff.has_alpha;
   assign rsp_repeat_count  = rsp_data_ff.repeat_count;
   assign rsp_last_of_image = rsp_data_ff.last_of_image;

   // skid only fills behind a waiting output
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a result while the output is empty");

   // pixel phase always has work left in both the image and the packet
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PIXEL |-> (pixels_left_ff != 32'd0 && packet_left_ff != 8'd0))
      else $error("pixel phase entered with no pixels or packet left");

   // a pixel result never carries a zero repeat count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == STATUS_PIXEL) |->
         rsp_data_ff.repeat_count != 8'd0)
      else $error("pixel result with zero repeat count");

   // error results always close the image
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != STATUS_PIXEL) |-> rsp_data_ff.last_of_image)
      else $error("error result without last_of_image");

endmodule
